### src/gtpw_pkg.sv
`timescale 1ns / 1ps
package gtpw_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;
    localparam int HEIGHT_BITS_DEF = 16;

    localparam int CFG_W   = 7;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int IN_H_W  = 16;
    localparam int DIST_W  = 22;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [DIST_W-1:0] DIST_MAX  = '1;
    localparam logic [CFG_W-1:0]  RESET_DIM = 7'd64;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_WALK = 1'b1;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic              func;
        logic [ROW_W-1:0]  load_row;
        logic [COL_W-1:0]  load_col;
        logic [IN_H_W-1:0] height;
        logic [ROW_W-1:0]  origin_row;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]  path_row;
        logic [COL_W-1:0]  path_col;
        logic [DIST_W-1:0] distance;
        logic              last;
    } res_item_t;

    // Classified command handed from the front end to the walker.
    typedef struct packed {
        logic              func;
        logic [CFG_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [IN_H_W-1:0] height;
        logic [CFG_W-1:0]  rows;
        logic [CFG_W-1:0]  cols;
    } cmd_t;

endpackage

### src/greedy_terrain_path_walker.sv
`timescale 1ns / 1ps
// A walk's first point reaches the result ports through the queue and the result register;
// each further column passes through S_RD1, S_RD2, S_RD3 and S_STEP, set by the three
// neighbor reads through the two-port height store.
// A load is written in S_IDLE. A two-entry command queue takes items while the walker is busy.
// Reset (rst_n low, asynchronous) empties the queue and returns rows and columns
// to 64; the height store is not cleared. Results cannot be stalled.
module greedy_terrain_path_walker
    import gtpw_pkg::*;
#(
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  in_item_t           item,
    output res_item_t          result,
    output logic               valid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    logic [CFG_W-1:0] rows_cfg_reg;
    logic [CFG_W-1:0] cols_cfg_reg;
    logic             cfg_write;
    logic             full;
    logic             empty;
    logic             push;
    logic             pop;
    cmd_t             cmd_in;
    cmd_t             cmd_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= RESET_DIM;
            cols_cfg_reg <= RESET_DIM;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_COLS)
            begin
                cols_cfg_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                rows_cfg_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ROWS) ? APB_W'(rows_cfg_reg) : APB_W'(cols_cfg_reg);

    gtpw_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .start    (start),
        .item     (item),
        .rows_cfg (rows_cfg_reg),
        .cols_cfg (cols_cfg_reg),
        .full     (full),
        .busy     (busy),
        .push     (push),
        .cmd      (cmd_in)
    );

    gtpw_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .full  (full),
        .pop   (pop),
        .dout  (cmd_out),
        .empty (empty)
    );

    gtpw_walk #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (cmd_out),
        .pop    (pop),
        .result (result),
        .valid  (valid)
    );

endmodule

### src/gtpw_front.sv
`timescale 1ns / 1ps
module gtpw_front
    import gtpw_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic             start,
    input  in_item_t         item,
    input  logic [CFG_W-1:0] rows_cfg,
    input  logic [CFG_W-1:0] cols_cfg,
    input  logic             full,
    output logic             busy,
    output logic             push,
    output cmd_t             cmd
);

    logic [CFG_W-1:0] rows_eff;
    logic [CFG_W-1:0] cols_eff;
    logic [CFG_W-1:0] start_ext;
    logic             load_ok;
    logic             accept;

    always_comb
    begin
        if (rows_cfg < CFG_W'(2))
        begin
            rows_eff = CFG_W'(2);
        end
        else if (32'(rows_cfg) > MAX_ROWS)
        begin
            rows_eff = CFG_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_cfg;
        end

        if (cols_cfg < CFG_W'(1))
        begin
            cols_eff = CFG_W'(1);
        end
        else if (32'(cols_cfg) > MAX_COLS)
        begin
            cols_eff = CFG_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = cols_cfg;
        end

        start_ext = CFG_W'(item.origin_row);
        if (start_ext > rows_eff - CFG_W'(1))
        begin
            start_ext = rows_eff - CFG_W'(1);
        end
    end

    assign load_ok = (32'(item.load_row) < MAX_ROWS) && (32'(item.load_col) < MAX_COLS);
    assign busy    = full;
    assign accept  = start && !full;

    // Loads that fall outside the map are taken and dropped here.
    assign push = accept && ((item.func == FUNC_WALK) || load_ok);

    always_comb
    begin
        cmd.func   = item.func;
        cmd.row    = (item.func == FUNC_WALK) ? start_ext : CFG_W'(item.load_row);
        cmd.col    = item.load_col;
        cmd.height = item.height;
        cmd.rows   = rows_eff;
        cmd.cols   = cols_eff;
    end

endmodule

### src/gtpw_queue.sv
`timescale 1ns / 1ps
module gtpw_queue
    import gtpw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### src/gtpw_walk.sv
`timescale 1ns / 1ps
module gtpw_walk
    import gtpw_pkg::*;
#(
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    input  cmd_t      head,
    output logic      pop,
    output res_item_t result,
    output logic      valid
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int D_W    = HEIGHT_BITS + 1;
    localparam int SUM_W  = ((HEIGHT_BITS > DIST_W) ? HEIGHT_BITS : DIST_W) + 1;

    // A missing neighbor is coded above every real height change.
    localparam logic [D_W-1:0] NO_NBR = {1'b1, {HEIGHT_BITS{1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;
    localparam logic [2:0] S_RD2  = 3'd2;
    localparam logic [2:0] S_RD3  = 3'd3;
    localparam logic [2:0] S_STEP = 3'd4;

    logic [HEIGHT_BITS-1:0] height_mem [DEPTH];

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   first_reg;
    logic                   first_next;
    res_item_t              res_reg;
    res_item_t              res_next;
    logic [CFG_W-1:0]       row_reg;
    logic [CFG_W-1:0]       row_next;
    logic [COL_W-1:0]       col_reg;
    logic [COL_W-1:0]       col_next;
    logic [DIST_W-1:0]      dist_reg;
    logic [DIST_W-1:0]      dist_next;
    logic [CFG_W-1:0]       rows_reg;
    logic [CFG_W-1:0]       rows_next;
    logic [CFG_W-1:0]       cols_reg;
    logic [CFG_W-1:0]       cols_next;
    logic [HEIGHT_BITS-1:0] here_reg;
    logic [HEIGHT_BITS-1:0] here_next;
    logic [HEIGHT_BITS-1:0] up_val_reg;
    logic [HEIGHT_BITS-1:0] up_val_next;
    logic [HEIGHT_BITS-1:0] dn_val_reg;
    logic [HEIGHT_BITS-1:0] dn_val_next;
    logic [HEIGHT_BITS-1:0] ac_val_reg;
    logic [HEIGHT_BITS-1:0] ac_val_next;
    logic [D_W-1:0]         up_d_reg;
    logic [D_W-1:0]         up_d_next;
    logic [D_W-1:0]         dn_d_reg;
    logic [D_W-1:0]         dn_d_next;
    logic [D_W-1:0]         ac_d_reg;
    logic [D_W-1:0]         ac_d_next;
    logic [HEIGHT_BITS-1:0] qa_reg;
    logic [HEIGHT_BITS-1:0] qb_reg;

    logic                   we;
    logic [ADDR_W-1:0]      wa;
    logic [HEIGHT_BITS-1:0] wd;
    logic [ADDR_W-1:0]      ra;
    logic [ADDR_W-1:0]      rb;
    logic [COL_W-1:0]       col_nx;
    logic                   go_up;
    logic                   go_down;
    logic [D_W-1:0]         step_d;
    logic [SUM_W-1:0]       sum;
    logic                   at_end;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CFG_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    function automatic logic [HEIGHT_BITS-1:0] abs_diff(input logic [HEIGHT_BITS-1:0] a,
                                                        input logic [HEIGHT_BITS-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign col_nx = col_reg + COL_W'(1);
    assign at_end = ({1'b0, col_nx} == cols_reg - CFG_W'(1));

    // Straight ahead wins every tie it is part of; an up/down tie goes down.
    always_comb
    begin
        go_up   = 1'b0;
        go_down = 1'b0;
        step_d  = ac_d_reg;
        if ((up_d_reg < ac_d_reg) && (up_d_reg < dn_d_reg))
        begin
            go_up  = 1'b1;
            step_d = up_d_reg;
        end
        else if ((dn_d_reg < up_d_reg) && (dn_d_reg < ac_d_reg))
        begin
            go_down = 1'b1;
            step_d  = dn_d_reg;
        end
        else if ((ac_d_reg <= up_d_reg) && (ac_d_reg <= dn_d_reg))
        begin
            step_d = ac_d_reg;
        end
        else
        begin
            go_down = 1'b1;
            step_d  = dn_d_reg;
        end
    end

    assign sum = SUM_W'(dist_reg) + SUM_W'(step_d[HEIGHT_BITS-1:0]);

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = 1'b0;
        first_next  = first_reg;
        res_next    = res_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        dist_next   = dist_reg;
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        here_next   = here_reg;
        up_val_next = up_val_reg;
        dn_val_next = dn_val_reg;
        ac_val_next = ac_val_reg;
        up_d_next   = up_d_reg;
        dn_d_next   = dn_d_reg;
        ac_d_next   = ac_d_reg;
        pop         = 1'b0;
        we          = 1'b0;
        wa          = cell_addr(head.row, head.col);
        wd          = HEIGHT_BITS'(head.height);
        ra          = cell_addr(row_reg, col_reg);
        rb          = cell_addr(row_reg, col_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head.func == FUNC_WALK)
                    begin
                        row_next          = head.row;
                        rows_next         = head.rows;
                        cols_next         = head.cols;
                        col_next          = '0;
                        dist_next         = '0;
                        first_next        = 1'b1;
                        ra                = cell_addr(head.row, '0);
                        valid_next        = 1'b1;
                        res_next.path_row = head.row[ROW_W-1:0];
                        res_next.path_col = '0;
                        res_next.distance = '0;
                        res_next.last     = (head.cols == CFG_W'(1));
                        if (head.cols != CFG_W'(1))
                        begin
                            state_next = S_RD1;
                        end
                    end
                    else
                    begin
                        we = 1'b1;
                    end
                end
            end

            S_RD1:
            begin
                if (first_reg)
                begin
                    here_next = qa_reg;
                end
                first_next = 1'b0;
                ra         = cell_addr(row_reg - CFG_W'(1), col_nx);
                rb         = cell_addr(row_reg + CFG_W'(1), col_nx);
                state_next = S_RD2;
            end

            S_RD2:
            begin
                up_val_next = qa_reg;
                dn_val_next = qb_reg;
                up_d_next   = (row_reg == '0) ? NO_NBR : {1'b0, abs_diff(here_reg, qa_reg)};
                dn_d_next   = (row_reg == rows_reg - CFG_W'(1)) ?
                              NO_NBR : {1'b0, abs_diff(here_reg, qb_reg)};
                ra          = cell_addr(row_reg, col_nx);
                state_next  = S_RD3;
            end

            S_RD3:
            begin
                ac_val_next = qa_reg;
                ac_d_next   = {1'b0, abs_diff(here_reg, qa_reg)};
                state_next  = S_STEP;
            end

            S_STEP:
            begin
                if (go_up)
                begin
                    row_next  = row_reg - CFG_W'(1);
                    here_next = up_val_reg;
                end
                else if (go_down)
                begin
                    row_next  = row_reg + CFG_W'(1);
                    here_next = dn_val_reg;
                end
                else
                begin
                    here_next = ac_val_reg;
                end
                dist_next         = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
                col_next          = col_nx;
                valid_next        = 1'b1;
                res_next.path_row = row_next[ROW_W-1:0];
                res_next.path_col = col_nx;
                res_next.distance = dist_next;
                res_next.last     = at_end;
                state_next        = at_end ? S_IDLE : S_RD1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        dist_reg   <= dist_next;
        rows_reg   <= rows_next;
        cols_reg   <= cols_next;
        here_reg   <= here_next;
        up_val_reg <= up_val_next;
        dn_val_reg <= dn_val_next;
        ac_val_reg <= ac_val_next;
        up_d_reg   <= up_d_next;
        dn_d_reg   <= dn_d_next;
        ac_d_reg   <= ac_d_next;
    end

    // Height store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            height_mem[wa] <= wd;
        end
        qa_reg <= height_mem[ra];
        qb_reg <= height_mem[rb];
    end

    assign result = res_reg;
    assign valid  = valid_reg;

endmodule
